>>> rtl/core/stl_pkg.sv
// Shared types and constants for the source text lexer.
`default_nettype none
package stl_pkg;
  localparam int OFFSET_BITS   = 20;
  localparam int POSITION_BITS = 16;
  localparam int MAX_TOK       = 3;

  localparam logic [4:0] K_IDENT  = 5'd0;
  localparam logic [4:0] K_NUMBER = 5'd1;
  localparam logic [4:0] K_FUNC   = 5'd2;
  localparam logic [4:0] K_IF     = 5'd3;
  localparam logic [4:0] K_RETURN = 5'd4;
  localparam logic [4:0] K_INT    = 5'd5;
  localparam logic [4:0] K_BOOL   = 5'd6;
  localparam logic [4:0] K_LBRACE = 5'd7;
  localparam logic [4:0] K_RBRACE = 5'd8;
  localparam logic [4:0] K_LPAREN = 5'd9;
  localparam logic [4:0] K_RPAREN = 5'd10;
  localparam logic [4:0] K_SEMI   = 5'd11;
  localparam logic [4:0] K_COLON  = 5'd12;
  localparam logic [4:0] K_COMMA  = 5'd13;
  localparam logic [4:0] K_ARROW  = 5'd14;
  localparam logic [4:0] K_MINUS  = 5'd15;
  localparam logic [4:0] K_PLUS   = 5'd16;
  localparam logic [4:0] K_STAR   = 5'd17;
  localparam logic [4:0] K_DIV    = 5'd18;
  localparam logic [4:0] K_GE     = 5'd19;
  localparam logic [4:0] K_GT     = 5'd20;
  localparam logic [4:0] K_LE     = 5'd21;
  localparam logic [4:0] K_LT     = 5'd22;
  localparam logic [4:0] K_END    = 5'd23;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_CHAR    = 2'd1;
  localparam logic [1:0] ERR_RANGE   = 2'd2;

  localparam logic [15:0] KW_IF     = 16'h6966;
  localparam logic [23:0] KW_INT    = 24'h696e74;
  localparam logic [31:0] KW_FUNC   = 32'h66756e63;
  localparam logic [31:0] KW_BOOL   = 32'h626f6f6c;
  localparam logic [47:0] KW_RETURN = 48'h72657475726e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [4:0]               token_kind;
    logic signed [31:0]       number_value;
    logic [OFFSET_BITS-1:0]   text_start;
    logic [OFFSET_BITS-1:0]   text_length;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] column;
    logic [1:0]               error_code;
    logic                     run_last;
  } out_t;

  // all tokens one byte produces
  typedef struct packed {
    logic [1:0]           cnt;
    out_t [MAX_TOK-1:0]   tok;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage
`default_nettype wire

>>> rtl/core/source_text_lexer_top.sv
// Source text lexer: byte in, tokens out.
// The first token of a byte passes the bundle queue and then the output register.
// Throughput: 1 byte per cycle while out_stall is low and each byte yields at
// most one token; a byte with k tokens uses the output port for k transfers.
// Reset (rst_n low, synchronous) clears lexer state, the bundle queue and output.
`default_nettype none
module source_text_lexer_top (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  stl_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output stl_pkg::out_t  out_data
);
  import stl_pkg::*;

  bundle_t bun, head;
  q_stat_t stat;
  logic    push, pop, acc;

  assign in_stall = stat.full;
  assign acc      = in_valid && !stat.full;

  stl_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .din(in_data), .bundle(bun), .push(push)
  );

  stl_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(bun), .pop(pop),
    .rdata(head), .stat(stat)
  );

  stl_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .stat(stat), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("bundle pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("bundle popped from empty queue");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.token_kind == K_END) |-> out_data.run_last)
    else $error("END token not marked last");
  a_eos_push: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.end_of_source) |-> push) else $error("last byte gave no END");
`endif
endmodule
`default_nettype wire

>>> rtl/core/stl_front.sv
// Lexer front end: takes one byte per transfer and forms the token bundle for it.
`default_nettype none
module stl_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  stl_pkg::in_t          din,
  output stl_pkg::bundle_t      bundle,
  output logic                  push
);
  import stl_pkg::*;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_NUMBER  = 4'd2;
  localparam logic [3:0] M_MINUS   = 4'd3;
  localparam logic [3:0] M_SLASH   = 4'd4;
  localparam logic [3:0] M_GT      = 4'd5;
  localparam logic [3:0] M_LT      = 4'd6;
  localparam logic [3:0] M_COMMENT = 4'd7;
  localparam logic [3:0] M_ERROR   = 4'd8;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  logic [3:0]               mode_r, mode_nxt;
  logic [32:0]              accum_r, accum_nxt;
  logic                     neg_r, neg_nxt;
  logic [OFFSET_BITS-1:0]   off_r, off_nxt, tokoff_r, tokoff_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [POSITION_BITS-1:0] tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [47:0]              win_r, win_nxt;
  logic [1:0]               err_r, err_nxt;
  logic [POSITION_BITS-1:0] eline_r, eline_nxt, ecol_r, ecol_nxt;

  function automatic logic [4:0] ident_kind(input logic [47:0] w,
                                            input logic [OFFSET_BITS-1:0] len);
    logic [4:0] k;
    k = K_IDENT;
    if (len == OFFSET_BITS'(2) && w[15:0] == KW_IF) k = K_IF;
    else if (len == OFFSET_BITS'(3) && w[23:0] == KW_INT) k = K_INT;
    else if (len == OFFSET_BITS'(4) && w[31:0] == KW_FUNC) k = K_FUNC;
    else if (len == OFFSET_BITS'(4) && w[31:0] == KW_BOOL) k = K_BOOL;
    else if (len == OFFSET_BITS'(6) && w == KW_RETURN) k = K_RETURN;
    return k;
  endfunction

  function automatic out_t mk_tok(input logic [4:0] kind, input logic [31:0] val,
                                  input logic [OFFSET_BITS-1:0] start,
                                  input logic [OFFSET_BITS-1:0] stop,
                                  input logic [POSITION_BITS-1:0] ln,
                                  input logic [POSITION_BITS-1:0] cl,
                                  input logic [1:0] err);
    out_t t;
    t.token_kind   = kind;
    t.number_value = val;
    t.text_start   = start;
    t.text_length  = stop - start;
    t.line         = ln;
    t.column       = cl;
    t.error_code   = err;
    t.run_last     = 1'b0;
    return t;
  endfunction

  logic [7:0]               c;
  logic [3:0]               dig;
  logic                     is_alpha, is_digit;
  logic [OFFSET_BITS-1:0]   nxt_off;
  logic [35:0]              prod;
  logic [4:0]               sk;
  logic                     fresh;
  logic [1:0]               n;
  out_t [MAX_TOK-1:0]       tk;
  out_t                     ft;
  logic                     fv;

  // true when the given mode holds a pending token that a flush must emit
  function automatic logic pend(input logic [3:0] m);
    return m == M_IDENT || m == M_NUMBER || m == M_MINUS || m == M_SLASH ||
           m == M_GT || m == M_LT;
  endfunction

  function automatic logic [4:0] pend_kind(input logic [3:0] m, input logic [47:0] w,
                                           input logic [OFFSET_BITS-1:0] len);
    logic [4:0] k;
    case (m)
      M_IDENT:  k = ident_kind(w, len);
      M_NUMBER: k = K_NUMBER;
      M_MINUS:  k = K_MINUS;
      M_SLASH:  k = K_DIV;
      M_GT:     k = K_GT;
      default:  k = K_LT;
    endcase
    return k;
  endfunction

  always_comb begin
    c        = din.ch;
    dig      = c[3:0];
    is_alpha = c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    is_digit = c inside {[8'h30:8'h39]};
    nxt_off  = off_r + OFFSET_BITS'(1);
    mode_nxt = mode_r;  accum_nxt = accum_r;  neg_nxt = neg_r;
    off_nxt  = off_r;   tokoff_nxt = tokoff_r;
    line_nxt = line_r;  col_nxt = col_r;
    tline_nxt = tline_r; tcol_nxt = tcol_r;
    win_nxt  = win_r;   err_nxt = err_r;
    eline_nxt = eline_r; ecol_nxt = ecol_r;
    fresh = 1'b0;
    n     = 2'd0;
    tk    = '0;
    prod  = {3'd0, accum_r} * 36'd10 + 36'(dig);
    case (c)
      "{":     sk = K_LBRACE;
      "}":     sk = K_RBRACE;
      "(":     sk = K_LPAREN;
      ")":     sk = K_RPAREN;
      ";":     sk = K_SEMI;
      ":":     sk = K_COLON;
      ",":     sk = K_COMMA;
      "+":     sk = K_PLUS;
      "*":     sk = K_STAR;
      default: sk = K_IDENT;
    endcase
    ft = mk_tok(pend_kind(mode_r, win_r, off_r - tokoff_r),
                neg_r ? 32'(33'd0 - accum_r) : accum_r[31:0],
                tokoff_r, off_r, tline_r, tcol_r, ERR_NONE);
    if (mode_r == M_NUMBER) begin
    end else begin
      ft.number_value = '0;
    end
    fv = 1'b0;

    if (mode_r != M_ERROR) begin
      case (mode_r)
        M_IDENT: begin
          if (is_alpha || is_digit) win_nxt = {win_r[39:0], c};
          else begin fv = 1'b1; fresh = 1'b1; end
        end
        M_NUMBER: begin
          if (is_digit) begin
            accum_nxt = prod[32:0];
            if (prod > (neg_r ? 36'd2147483648 : 36'd2147483647)) begin
              err_nxt = ERR_RANGE; eline_nxt = tline_r; ecol_nxt = tcol_r;
              mode_nxt = M_ERROR;
            end
          end else begin fv = 1'b1; fresh = 1'b1; end
        end
        M_MINUS: begin
          if (c == ">") begin
            ft = mk_tok(K_ARROW, '0, tokoff_r, nxt_off, tline_r, tcol_r, ERR_NONE);
            fv = 1'b1;
            mode_nxt = M_IDLE;
          end else if (is_digit) begin
            mode_nxt = M_NUMBER; neg_nxt = 1'b1; accum_nxt = 33'(dig);
          end else begin fv = 1'b1; fresh = 1'b1; end
        end
        M_SLASH: begin
          if (c == "/") mode_nxt = M_COMMENT;
          else begin fv = 1'b1; fresh = 1'b1; end
        end
        M_GT, M_LT: begin
          if (c == "=") begin
            ft = mk_tok((mode_r == M_GT) ? K_GE : K_LE, '0, tokoff_r, nxt_off,
                        tline_r, tcol_r, ERR_NONE);
            fv = 1'b1;
            mode_nxt = M_IDLE;
          end else begin fv = 1'b1; fresh = 1'b1; end
        end
        M_COMMENT: begin
          if (c == 8'h0a) mode_nxt = M_IDLE;
        end
        default: fresh = 1'b1;
      endcase
      if (fv) begin
        tk[n] = ft; n = n + 2'd1;
      end
      if (fresh) begin
        mode_nxt = M_IDLE;
        if (c == " " || c == 8'h0a) begin
        end else if (sk != K_IDENT) begin
          tk[n] = mk_tok(sk, '0, off_r, nxt_off, line_r, col_r, ERR_NONE);
          n = n + 2'd1;
        end else if (c == "-" || c == "/" || c == ">" || c == "<" || is_alpha || is_digit)
        begin
          tokoff_nxt = off_r; tline_nxt = line_r; tcol_nxt = col_r;
          if (c == "-") mode_nxt = M_MINUS;
          else if (c == "/") mode_nxt = M_SLASH;
          else if (c == ">") mode_nxt = M_GT;
          else if (c == "<") mode_nxt = M_LT;
          else if (is_alpha) begin
            mode_nxt = M_IDENT; win_nxt = 48'(c);
          end else begin
            mode_nxt = M_NUMBER; neg_nxt = 1'b0; accum_nxt = 33'(dig);
          end
        end else begin
          err_nxt = ERR_CHAR; eline_nxt = line_r; ecol_nxt = col_r;
          mode_nxt = M_ERROR;
        end
      end
      // last byte closes whatever token is still open
      if (din.end_of_source && pend(mode_nxt) && n < 2'd3) begin
        tk[n] = mk_tok(pend_kind(mode_nxt, win_nxt, nxt_off - tokoff_nxt),
                       (mode_nxt != M_NUMBER) ? 32'd0 :
                       (neg_nxt ? 32'(33'd0 - accum_nxt) : accum_nxt[31:0]),
                       tokoff_nxt, nxt_off, tline_nxt, tcol_nxt, ERR_NONE);
        n = n + 2'd1;
      end
      if (c == 8'h0a) begin
        if (line_r != POS_MAX) line_nxt = line_r + POS_ONE;
        col_nxt = POS_ONE;
      end else if (col_r != POS_MAX) begin
        col_nxt = col_r + POS_ONE;
      end
      off_nxt = nxt_off;
    end

    if (din.end_of_source) begin
      if (n < 2'd3) begin
        if (err_nxt != ERR_NONE)
          tk[n] = mk_tok(K_END, '0, off_r, off_r, eline_nxt, ecol_nxt, err_nxt);
        else
          tk[n] = mk_tok(K_END, '0, off_r, off_r, line_r, col_r, ERR_NONE);
        n = n + 2'd1;
      end
      mode_nxt = M_IDLE; accum_nxt = '0; neg_nxt = 1'b0;
      off_nxt = '0; tokoff_nxt = '0;
      line_nxt = POS_ONE; col_nxt = POS_ONE; tline_nxt = POS_ONE; tcol_nxt = POS_ONE;
      win_nxt = '0; err_nxt = ERR_NONE; eline_nxt = '0; ecol_nxt = '0;
    end
    if (n != 2'd0) tk[n - 2'd1].run_last = 1'b1;
    bundle.cnt = n;
    bundle.tok = tk;
    push = acc && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;   accum_r <= '0;  neg_r <= 1'b0;
      off_r <= '0;        tokoff_r <= '0;
      line_r <= POS_ONE;  col_r <= POS_ONE;
      tline_r <= POS_ONE; tcol_r <= POS_ONE;
      win_r <= '0;        err_r <= ERR_NONE;
      eline_r <= '0;      ecol_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;   accum_r <= accum_nxt; neg_r <= neg_nxt;
      off_r <= off_nxt;     tokoff_r <= tokoff_nxt;
      line_r <= line_nxt;   col_r <= col_nxt;
      tline_r <= tline_nxt; tcol_r <= tcol_nxt;
      win_r <= win_nxt;     err_r <= err_nxt;
      eline_r <= eline_nxt; ecol_r <= ecol_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/stl_queue.sv
// Two-entry bundle queue between lexer front and token back end.
`default_nettype none
module stl_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  stl_pkg::bundle_t   wdata,
  input  wire logic          pop,
  output stl_pkg::bundle_t   rdata,
  output stl_pkg::q_stat_t   stat
);
  import stl_pkg::*;

  bundle_t    mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rdata   = mem_r[rp_r];
    stat.full  = cnt_r == 2'd2;
    stat.empty = cnt_r == 2'd0;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/stl_back.sv
// Token back end: unpacks bundles into one result per transfer via an output register.
`default_nettype none
module stl_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  stl_pkg::bundle_t   head,
  input  stl_pkg::q_stat_t   stat,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output stl_pkg::out_t      out_data
);
  import stl_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  out_t       dat_r;
  logic       load, last;

  always_comb begin
    load    = !stat.empty && (!vld_r || !out_stall);
    last    = idx_r == head.cnt - 2'd1;
    pop     = load && last;
    idx_nxt = load ? (last ? 2'd0 : idx_r + 2'd1) : idx_r;
    vld_nxt = load || (vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (load) dat_r <= head.tok[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0; vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt; vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = dat_r;
endmodule
`default_nettype wire
